>>> rtl/bps_pkg.sv
// bps_pkg: shared constants, codes and types of the buzzer pattern sequencer
// used by every module of the block, depends on nothing

package bps_pkg;

   localparam int TIME_BITS = 16;
   localparam int CFG_BITS  = 16;
   localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int IDX_BITS  = 3;
   localparam int HZ_BITS   = 12;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   localparam logic [2:0] PAT_NONE    = 3'd0;
   localparam logic [2:0] PAT_SHORT   = 3'd1;
   localparam logic [2:0] PAT_SUCCESS = 3'd2;
   localparam logic [2:0] PAT_WARNING = 3'd3;
   localparam logic [2:0] PAT_ERROR   = 3'd4;

   localparam logic [1:0] STEP_0 = 2'd0;
   localparam logic [1:0] STEP_1 = 2'd1;
   localparam logic [1:0] STEP_2 = 2'd2;
   localparam logic [1:0] STEP_3 = 2'd3;

   localparam logic [HZ_BITS-1:0] HZ_SILENT = 12'd0;
   localparam logic [HZ_BITS-1:0] HZ_HIGH   = 12'd2000;
   localparam logic [HZ_BITS-1:0] HZ_HIGHER = 12'd2500;
   localparam logic [HZ_BITS-1:0] HZ_MID    = 12'd1500;
   localparam logic [HZ_BITS-1:0] HZ_LOW    = 12'd1000;

   localparam logic [IDX_BITS-1:0] REG_SHORT_ON   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_SUCCESS_ON = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_SUCCESS_GAP = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_WARNING_ON = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_ERROR_ON   = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_ERROR_OFF  = 3'd5;

   typedef struct packed {
      logic [CFG_BITS-1:0] short_on_ms;
      logic [CFG_BITS-1:0] success_on_ms;
      logic [CFG_BITS-1:0] success_gap_ms;
      logic [CFG_BITS-1:0] warning_on_ms;
      logic [CFG_BITS-1:0] error_on_ms;
      logic [CFG_BITS-1:0] error_off_ms;
   } bps_cfg_type;

endpackage

>>> rtl/bps_csr.sv
// bps_csr: pattern timing registers written over the csr port
// depends on bps_pkg

module bps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bps_pkg::IDX_BITS-1:0]     csr_index,
   input  logic [bps_pkg::CFG_BITS-1:0]     csr_data,
   output bps_pkg::bps_cfg_type             cfg
);

   bps_pkg::bps_cfg_type cfg_ff;
   bps_pkg::bps_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bps_pkg::REG_SHORT_ON:    cfg_in.short_on_ms    = csr_data;
            bps_pkg::REG_SUCCESS_ON:  cfg_in.success_on_ms  = csr_data;
            bps_pkg::REG_SUCCESS_GAP: cfg_in.success_gap_ms = csr_data;
            bps_pkg::REG_WARNING_ON:  cfg_in.warning_on_ms  = csr_data;
            bps_pkg::REG_ERROR_ON:    cfg_in.error_on_ms    = csr_data;
            bps_pkg::REG_ERROR_OFF:   cfg_in.error_off_ms   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_on_ms    <= 16'd100;
         cfg_ff.success_on_ms  <= 16'd150;
         cfg_ff.success_gap_ms <= 16'd100;
         cfg_ff.warning_on_ms  <= 16'd300;
         cfg_ff.error_on_ms    <= 16'd500;
         cfg_ff.error_off_ms   <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/bps_core.sv
// bps_core: request register, pattern step logic, state and result register
// depends on bps_pkg

module bps_core (
   input  logic                            clock,
   input  logic                            reset,
   input  bps_pkg::bps_cfg_type            cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [2:0]                      req_pattern_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tone_on,
   output logic [bps_pkg::HZ_BITS-1:0]     rsp_tone_hz,
   output logic                            rsp_busy_res
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [1:0]                        s1_action_ff;
   logic [2:0]                        s1_pattern_ff;
   logic                              advance, accept;

   logic                              running_ff, running_in;
   logic [2:0]                        pattern_ff, pattern_in;
   logic [1:0]                        step_ff, step_in;
   logic [bps_pkg::TIME_BITS-1:0]     elapsed_ff, elapsed_in, elapsed_inc;
   logic [bps_pkg::HZ_BITS-1:0]       freq_ff, freq_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_tone_on_ff;
   logic [bps_pkg::HZ_BITS-1:0]       rsp_tone_hz_ff;
   logic                              rsp_busy_ff;

   logic [bps_pkg::CMP_BITS-1:0]      el_x;
   logic                              ge_short, ge_succ_on, ge_succ_gap;
   logic                              ge_warn, ge_err_on, ge_err_off;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign elapsed_inc = (elapsed_ff == bps_pkg::TIME_MAX) ? elapsed_ff
                                                          : elapsed_ff + 1'b1;
   assign el_x = bps_pkg::CMP_BITS'(elapsed_inc);

   assign ge_short    = el_x >= bps_pkg::CMP_BITS'(cfg.short_on_ms);
   assign ge_succ_on  = el_x >= bps_pkg::CMP_BITS'(cfg.success_on_ms);
   assign ge_succ_gap = el_x >= bps_pkg::CMP_BITS'(cfg.success_gap_ms);
   assign ge_warn     = el_x >= bps_pkg::CMP_BITS'(cfg.warning_on_ms);
   assign ge_err_on   = el_x >= bps_pkg::CMP_BITS'(cfg.error_on_ms);
   assign ge_err_off  = el_x >= bps_pkg::CMP_BITS'(cfg.error_off_ms);

   always_comb begin
      logic halt;
      logic go;
      logic [1:0] go_step;
      logic [bps_pkg::HZ_BITS-1:0] go_freq;
      halt       = 1'b0;
      go         = 1'b0;
      go_step    = bps_pkg::STEP_0;
      go_freq    = bps_pkg::HZ_SILENT;
      running_in = running_ff;
      pattern_in = pattern_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      freq_in    = freq_ff;
      if (advance) begin
         case (s1_action_ff)
            bps_pkg::ACT_TICK: begin
               if (running_ff) begin
                  elapsed_in = elapsed_inc;
                  case (pattern_ff)
                     bps_pkg::PAT_SHORT: begin
                        if (step_ff == bps_pkg::STEP_0) begin
                           go = 1'b1; go_step = bps_pkg::STEP_1; go_freq = bps_pkg::HZ_HIGH;
                        end else if (ge_short) begin
                           halt = 1'b1;
                        end
                     end
                     bps_pkg::PAT_SUCCESS: begin
                        if (step_ff == bps_pkg::STEP_0) begin
                           go = 1'b1; go_step = bps_pkg::STEP_1; go_freq = bps_pkg::HZ_HIGH;
                        end else if (step_ff == bps_pkg::STEP_1 && ge_succ_on) begin
                           go = 1'b1; go_step = bps_pkg::STEP_2;
                        end else if (step_ff == bps_pkg::STEP_2 && ge_succ_gap) begin
                           go = 1'b1; go_step = bps_pkg::STEP_3;
                           go_freq = bps_pkg::HZ_HIGHER;
                        end else if (step_ff == bps_pkg::STEP_3 && ge_succ_on) begin
                           halt = 1'b1;
                        end
                     end
                     bps_pkg::PAT_WARNING: begin
                        if (step_ff == bps_pkg::STEP_0) begin
                           go = 1'b1; go_step = bps_pkg::STEP_1; go_freq = bps_pkg::HZ_MID;
                        end else if (step_ff == bps_pkg::STEP_1 && ge_warn) begin
                           halt = 1'b1;
                        end
                     end
                     bps_pkg::PAT_ERROR: begin
                        if (step_ff == bps_pkg::STEP_0) begin
                           go = 1'b1; go_step = bps_pkg::STEP_1; go_freq = bps_pkg::HZ_LOW;
                        end else if (step_ff == bps_pkg::STEP_1 && ge_err_on) begin
                           go = 1'b1; go_step = bps_pkg::STEP_2;
                        end else if (step_ff == bps_pkg::STEP_2 && ge_err_off) begin
                           go = 1'b1; go_step = bps_pkg::STEP_0;
                        end
                     end
                     default: halt = 1'b1;
                  endcase
               end
            end
            bps_pkg::ACT_START: begin
               freq_in    = bps_pkg::HZ_SILENT;
               pattern_in = s1_pattern_ff;
               step_in    = bps_pkg::STEP_0;
               elapsed_in = '0;
               running_in = 1'b1;
            end
            bps_pkg::ACT_STOP: halt = 1'b1;
            default: ;
         endcase
         if (go) begin
            step_in    = go_step;
            freq_in    = go_freq;
            elapsed_in = '0;
         end
         if (halt) begin
            freq_in    = bps_pkg::HZ_SILENT;
            running_in = 1'b0;
            pattern_in = bps_pkg::PAT_NONE;
            step_in    = bps_pkg::STEP_0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         pattern_ff   <= bps_pkg::PAT_NONE;
         step_ff      <= bps_pkg::STEP_0;
         elapsed_ff   <= '0;
         freq_ff      <= bps_pkg::HZ_SILENT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         pattern_ff   <= pattern_in;
         step_ff      <= step_in;
         elapsed_ff   <= elapsed_in;
         freq_ff      <= freq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff  <= req_action;
         s1_pattern_ff <= req_pattern_code;
      end
      if (advance) begin
         rsp_tone_on_ff <= (freq_in != bps_pkg::HZ_SILENT);
         rsp_tone_hz_ff <= freq_in;
         rsp_busy_ff    <= running_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tone_on  = rsp_tone_on_ff;
   assign rsp_tone_hz  = rsp_tone_hz_ff;
   assign rsp_busy_res = rsp_busy_ff;

   // idle block is always silent
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> freq_ff == bps_pkg::HZ_SILENT)
      else $error("tone set while idle");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      step_ff != bps_pkg::STEP_0 |-> running_ff)
      else $error("step advanced while idle");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      advance && s1_action_ff == bps_pkg::ACT_TICK && !running_ff
      |=> $stable(elapsed_ff) && $stable(pattern_ff) && !running_ff)
      else $error("idle tick changed state");

   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !advance |=> !rsp_valid_ff)
      else $error("request result repeated");

endmodule

>>> rtl/buzzer_pattern_sequencer.sv
// buzzer_pattern_sequencer: top level, csr registers and the step core
// depends on bps_pkg, bps_csr, bps_core
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_action, req_pattern_code
//   rsp      out        rsp_valid/rsp_stall  rsp_tone_on, rsp_tone_hz, rsp_busy_res
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one request per cycle sustained unless rsp stalls; each request is registered,
// then the step logic updates the pattern state and the result register from it.
// the result is valid once it has passed the request register and the result register.
// reset is synchronous: pattern idle, tone silent, timing registers at defaults.
// a stalled result holds the request register and stalls req; csr is always ready.

module buzzer_pattern_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [2:0]                      req_pattern_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tone_on,
   output logic [bps_pkg::HZ_BITS-1:0]     rsp_tone_hz,
   output logic                            rsp_busy_res,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bps_pkg::IDX_BITS-1:0]    csr_index,
   input  logic [bps_pkg::CFG_BITS-1:0]    csr_data
);

   bps_pkg::bps_cfg_type cfg;

   bps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bps_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pattern_code (req_pattern_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tone_on      (rsp_tone_on),
      .rsp_tone_hz      (rsp_tone_hz),
      .rsp_busy_res     (rsp_busy_res)
   );

endmodule
